// ===== sv/bsle_pkg.sv =====
// shared constants, op codes and control types for the sorted list engine
package bsle_pkg;

    localparam int CAPACITY     = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int KEY_W        = 32;
    localparam int FIELD_W      = 32;
    localparam int IDX_W        = 4;
    localparam int MODE_W       = 3;
    localparam int ENTRY_W      = 5;
    localparam int CNT_W        = $clog2(CAPACITY + 1);

    localparam int IN_FIELDS_W  = KEY_W + FIELD_W + IDX_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + KEY_W + FIELD_W + ENTRY_W + 1 + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD_TAIL   = 3'd0,
        MODE_ADD_HEAD   = 3'd1,
        MODE_ADD_SORTED = 3'd2,
        MODE_DROP_TAIL  = 3'd3,
        MODE_DROP_HEAD  = 3'd4,
        MODE_DROP_KEY   = 3'd5,
        MODE_READ_INDEX = 3'd6,
        MODE_FIND_KEY   = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXEC
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                    cmp_en;
        logic                    ins_en;
        logic                    del_en;
        logic [KEY_W-1:0]        new_key;
        logic [PAYLOAD_BITS-1:0] new_payload;
    } cell_ctrl_t;

endpackage

// ===== sv/bsle_cell.sv =====
// one list slot: holds a record, compares it to the op key and shifts with its neighbors
module bsle_cell
    import bsle_pkg::*;
(
    input  logic                    clk,
    input  cell_ctrl_t              ctrl,
    input  logic                    use_chain,
    input  logic                    sorted,
    input  logic                    valid,
    input  logic                    thr,
    input  logic                    seen_in,
    input  logic                    ge_left,
    input  logic [KEY_W-1:0]        left_key,
    input  logic [PAYLOAD_BITS-1:0] left_payload,
    input  logic [KEY_W-1:0]        right_key,
    input  logic [PAYLOAD_BITS-1:0] right_payload,
    output logic                    seen_out,
    output logic                    ge,
    output logic [KEY_W-1:0]        key,
    output logic [PAYLOAD_BITS-1:0] payload
);

    logic [KEY_W-1:0]        key_reg;
    logic [KEY_W-1:0]        key_next;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [PAYLOAD_BITS-1:0] payload_next;
    logic                    lt_reg;
    logic                    lt_next;
    logic                    eq_reg;
    logic                    eq_next;
    logic                    stop;

    // stop marks the insert point (sorted) or the first match
    assign stop     = valid & (sorted ? ~lt_reg : eq_reg);
    assign seen_out = seen_in | stop;
    assign ge       = thr | (use_chain & seen_out);
    assign key      = key_reg;
    assign payload  = payload_reg;

    always_comb
    begin
        lt_next      = lt_reg;
        eq_next      = eq_reg;
        key_next     = key_reg;
        payload_next = payload_reg;
        if (ctrl.cmp_en)
        begin
            lt_next = $signed(key_reg) < $signed(ctrl.new_key);
            eq_next = key_reg == ctrl.new_key;
        end
        if (ctrl.ins_en)
        begin
            if (ge_left)
            begin
                key_next     = left_key;
                payload_next = left_payload;
            end
            else if (ge)
            begin
                key_next     = ctrl.new_key;
                payload_next = ctrl.new_payload;
            end
        end
        else if (ctrl.del_en && ge)
        begin
            key_next     = right_key;
            payload_next = right_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
        lt_reg      <= lt_next;
        eq_reg      <= eq_next;
    end

endmodule

// ===== sv/bounded_sorted_list_engine_unit.sv =====
// top level of the sorted list engine: controller, row of cells and result register
//
// channel   dir  handshake          contents
// s_*       in   s_tvalid/s_tready  tuser: mode; tdata: key, payload, read index
// m_*       out  m_tvalid/m_tready  tdata: ok, key, payload, count, full, empty
//
// for each item the compare state checks every cell against the op key; the execute
// state resolves the first hit along the cell chain, shifts the row and loads the result
// a new item is taken in the same cycle the previous result is loaded
// reset clears the count, the controller and the result valid; cell contents
// are left as they are and only read below the count
// a result not yet taken holds the engine in its execute cycle
module bounded_sorted_list_engine_unit
    import bsle_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [31:0] record_key, [63:32] record_payload, [67:64] read_index, rest zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [2:0] mode
    input  logic [MODE_W-1:0]      s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] ok, [32:1] found_key, [64:33] found_payload, [69:65] entry_count,
    // [70] is_full, [71] is_empty
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    // current op, captured on the input transfer
    mode_t                   mode_reg;
    mode_t                   mode_next;
    logic [KEY_W-1:0]        op_key_reg;
    logic [KEY_W-1:0]        op_key_next;
    logic [FIELD_W-1:0]      op_payload_reg;
    logic [FIELD_W-1:0]      op_payload_next;
    logic [IDX_W-1:0]        op_idx_reg;
    logic [IDX_W-1:0]        op_idx_next;

    state_t                  state_reg;
    state_t                  state_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic [OUT_TDATA_W-1:0]  out_data_reg;
    logic [OUT_TDATA_W-1:0]  out_data_next;

    logic                    in_xfer;
    logic                    out_free;
    logic                    exec_fire;
    logic                    is_full;
    logic                    is_empty;
    logic                    found;
    logic                    ok;
    logic                    use_chain;
    logic                    sorted;
    logic [CNT_W-1:0]        thr_val;
    logic [CNT_W-1:0]        res_count;
    logic [KEY_W-1:0]        rd_key;
    logic [PAYLOAD_BITS-1:0] rd_payload;
    cell_ctrl_t              ctrl;

    // per-cell wiring of the row
    logic [CAPACITY-1:0]     cell_valid;
    logic [CAPACITY-1:0]     cell_thr;
    logic [CAPACITY-1:0]     cell_ge;
    logic [CAPACITY-1:0]     cell_hit;
    logic [CAPACITY-1:0]     cell_sel;
    logic [CAPACITY:0]       seen;
    logic [KEY_W-1:0]        cell_key     [CAPACITY];
    logic [PAYLOAD_BITS-1:0] cell_payload [CAPACITY];

    assign in_xfer   = s_tvalid & s_tready;
    assign out_free  = ~m_valid_reg | m_tready;
    assign exec_fire = (state_reg == ST_EXEC) & out_free;
    assign s_tready  = (state_reg == ST_IDLE) | exec_fire;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = out_data_reg;

    assign is_full  = count_reg == CNT_W'(CAPACITY);
    assign is_empty = count_reg == '0;
    // first match anywhere in the valid part of the row
    assign found    = seen[CAPACITY];

    // controller
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                    state_next = ST_CMP;
            end
            ST_CMP:
                state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (out_free)
                    state_next = in_xfer ? ST_CMP : ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // op decode: split point of the row and chain use
    always_comb
    begin
        thr_val   = count_reg;
        use_chain = 1'b0;
        sorted    = 1'b0;
        unique case (mode_reg)
            MODE_ADD_TAIL:
                thr_val = count_reg;
            MODE_ADD_HEAD:
                thr_val = '0;
            MODE_ADD_SORTED:
            begin
                use_chain = 1'b1;
                sorted    = 1'b1;
            end
            MODE_DROP_TAIL:
                thr_val = count_reg - CNT_W'(1);
            MODE_DROP_HEAD:
                thr_val = '0;
            MODE_DROP_KEY:
                use_chain = 1'b1;
            MODE_READ_INDEX:
                thr_val = count_reg;
            MODE_FIND_KEY:
                use_chain = 1'b1;
            default:
                thr_val = count_reg;
        endcase
    end

    // op decode: success and row controls
    always_comb
    begin
        ok = 1'b0;
        unique case (mode_reg)
            MODE_ADD_TAIL:
                ok = ~is_full;
            MODE_ADD_HEAD:
                ok = ~is_full;
            MODE_ADD_SORTED:
                ok = ~is_full;
            MODE_DROP_TAIL:
                ok = ~is_empty;
            MODE_DROP_HEAD:
                ok = ~is_empty;
            MODE_DROP_KEY:
                ok = found;
            MODE_READ_INDEX:
                ok = 32'(op_idx_reg) < 32'(count_reg);
            MODE_FIND_KEY:
                ok = found;
            default:
                ok = 1'b0;
        endcase
        ctrl.cmp_en      = state_reg == ST_CMP;
        ctrl.ins_en      = exec_fire & ok & (mode_reg == MODE_ADD_TAIL
                           || mode_reg == MODE_ADD_HEAD || mode_reg == MODE_ADD_SORTED);
        ctrl.del_en      = exec_fire & ok & (mode_reg == MODE_DROP_TAIL
                           || mode_reg == MODE_DROP_HEAD || mode_reg == MODE_DROP_KEY);
        ctrl.new_key     = op_key_reg;
        ctrl.new_payload = op_payload_reg[PAYLOAD_BITS-1:0];
    end

    // per-cell position flags and read select
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_valid[i] = CNT_W'(i) < count_reg;
            cell_thr[i]   = CNT_W'(i) >= thr_val;
        end
        cell_hit[0] = cell_ge[0];
        for (int i = 1; i < CAPACITY; i++)
            cell_hit[i] = cell_ge[i] & ~cell_ge[i-1];
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (mode_reg == MODE_FIND_KEY)
                cell_sel[i] = cell_hit[i];
            else
                cell_sel[i] = 32'(op_idx_reg) == 32'(i);
        end
        rd_key     = '0;
        rd_payload = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_sel[i])
            begin
                rd_key     = rd_key | cell_key[i];
                rd_payload = rd_payload | cell_payload[i];
            end
        end
    end

    assign seen[0] = 1'b0;

    // the row: each cell takes from its left neighbor on insert, right on remove
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic                    ge_left;
        logic [KEY_W-1:0]        left_key;
        logic [PAYLOAD_BITS-1:0] left_payload;
        logic [KEY_W-1:0]        right_key;
        logic [PAYLOAD_BITS-1:0] right_payload;

        if (g == 0)
        begin : g_first
            assign ge_left      = 1'b0;
            assign left_key     = cell_key[g];
            assign left_payload = cell_payload[g];
        end
        else
        begin : g_mid
            assign ge_left      = cell_ge[g-1];
            assign left_key     = cell_key[g-1];
            assign left_payload = cell_payload[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_key     = cell_key[g];
            assign right_payload = cell_payload[g];
        end
        else
        begin : g_inner
            assign right_key     = cell_key[g+1];
            assign right_payload = cell_payload[g+1];
        end

        bsle_cell u_cell (
            .clk           (clk),
            .ctrl          (ctrl),
            .use_chain     (use_chain),
            .sorted        (sorted),
            .valid         (cell_valid[g]),
            .thr           (cell_thr[g]),
            .seen_in       (seen[g]),
            .ge_left       (ge_left),
            .left_key      (left_key),
            .left_payload  (left_payload),
            .right_key     (right_key),
            .right_payload (right_payload),
            .seen_out      (seen[g+1]),
            .ge            (cell_ge[g]),
            .key           (cell_key[g]),
            .payload       (cell_payload[g])
        );
    end

    // count update and result
    always_comb
    begin
        res_count = count_reg;
        if (ctrl.ins_en)
            res_count = count_reg + CNT_W'(1);
        else if (ctrl.del_en)
            res_count = count_reg - CNT_W'(1);
        count_next = res_count;

        m_valid_next  = m_valid_reg;
        out_data_next = out_data_reg;
        if (m_tready)
            m_valid_next = 1'b0;
        if (exec_fire)
        begin
            m_valid_next  = 1'b1;
            out_data_next = '0;
            out_data_next[OUT_FIELDS_W-1:0] = {
                res_count == '0,
                res_count == CNT_W'(CAPACITY),
                ENTRY_W'(res_count),
                (ok && (mode_reg == MODE_READ_INDEX || mode_reg == MODE_FIND_KEY))
                    ? FIELD_W'(rd_payload) : FIELD_W'(0),
                (ok && (mode_reg == MODE_READ_INDEX || mode_reg == MODE_FIND_KEY))
                    ? rd_key : KEY_W'(0),
                ok
            };
        end

        mode_next       = mode_reg;
        op_key_next     = op_key_reg;
        op_payload_next = op_payload_reg;
        op_idx_next     = op_idx_reg;
        if (in_xfer)
        begin
            mode_next       = mode_t'(s_tuser);
            op_key_next     = s_tdata[KEY_W-1:0];
            op_payload_next = s_tdata[KEY_W+FIELD_W-1:KEY_W];
            op_idx_next     = s_tdata[KEY_W+FIELD_W+IDX_W-1:KEY_W+FIELD_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        op_key_reg     <= op_key_next;
        op_payload_reg <= op_payload_next;
        op_idx_reg     <= op_idx_next;
        out_data_reg   <= out_data_next;
    end

`ifndef SYNTHESIS
    // the count never runs past the row
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= CAPACITY)
        else $error("list count beyond capacity");

    // an accepted item always goes to the compare cycle next
    a_xfer_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == ST_CMP)
        else $error("accepted item did not enter compare");

    // the count only moves in a cycle that loads a result
    a_count_moves_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
        !exec_fire |=> $stable(count_reg))
        else $error("count changed outside execute");

    // a new result appears only after a compare cycle
    a_result_after_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |-> $past(state_reg) == ST_CMP || $past(state_reg) == ST_EXEC)
        else $error("result loaded without compare");
`endif

endmodule

// ===== bench/bsle_reply_checker.sv =====
// checker for the sorted list engine: tracks the list, predicts each reply and compares
`timescale 1ns / 1ps

module bsle_reply_checker
    import bsle_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [MODE_W-1:0]      s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     mismatch_count,
    output int                     replies_outstanding
);

    // reply bit positions
    localparam int OK_B     = 0;
    localparam int FK_LO    = 1;
    localparam int FP_LO    = FK_LO + KEY_W;
    localparam int CNT_LO   = FP_LO + FIELD_W;
    localparam int FULL_B   = CNT_LO + ENTRY_W;
    localparam int EMPTY_B  = FULL_B + 1;

    typedef struct packed {
        logic               ok;
        logic [KEY_W-1:0]   key;
        logic [FIELD_W-1:0] payload;
        logic [ENTRY_W-1:0] count;
        logic               full;
        logic               empty;
    } list_reply_t;

    logic [KEY_W-1:0]        held_key     [CAPACITY];
    logic [PAYLOAD_BITS-1:0] held_payload [CAPACITY];
    int                      held_count;

    list_reply_t list_replies [$];
    list_reply_t oldest;
    int          bad_fields;

    assign mismatch_count = bad_fields;

    // first position holding the key, or the count when absent
    function automatic int key_position(logic [KEY_W-1:0] k);
        int p;
        p = 0;
        while (p < held_count && held_key[p] != k)
            p++;
        return p;
    endfunction

    function automatic list_reply_t run_list_op(mode_t op, logic [KEY_W-1:0] k,
                                                logic [FIELD_W-1:0] p, logic [IDX_W-1:0] idx);
        list_reply_t r;
        int          pos;
        int          i;
        r = '0;
        case (op) inside
            MODE_ADD_TAIL, MODE_ADD_HEAD, MODE_ADD_SORTED:
            begin
                if (held_count < CAPACITY)
                begin
                    pos = (op == MODE_ADD_TAIL) ? held_count : 0;
                    // sorted add lands before the first key not below it
                    if (op == MODE_ADD_SORTED)
                        while (pos < held_count && $signed(held_key[pos]) < $signed(k))
                            pos++;
                    for (i = held_count; i > pos; i--)
                    begin
                        held_key[i]     = held_key[i-1];
                        held_payload[i] = held_payload[i-1];
                    end
                    held_key[pos]     = k;
                    held_payload[pos] = p[PAYLOAD_BITS-1:0];
                    held_count++;
                    r.ok = 1'b1;
                end
            end
            MODE_DROP_TAIL, MODE_DROP_HEAD, MODE_DROP_KEY:
            begin
                if (held_count > 0)
                begin
                    if (op == MODE_DROP_TAIL)
                        pos = held_count - 1;
                    else if (op == MODE_DROP_HEAD)
                        pos = 0;
                    else
                        pos = key_position(k);
                    if (pos < held_count)
                    begin
                        for (i = pos; i + 1 < held_count; i++)
                        begin
                            held_key[i]     = held_key[i+1];
                            held_payload[i] = held_payload[i+1];
                        end
                        held_count--;
                        r.ok = 1'b1;
                    end
                end
            end
            default:
            begin
                pos = (op == MODE_READ_INDEX) ? int'(idx) : key_position(k);
                if (pos < held_count)
                begin
                    r.key     = held_key[pos];
                    r.payload = FIELD_W'(held_payload[pos]);
                    r.ok      = 1'b1;
                end
            end
        endcase
        r.count = ENTRY_W'(held_count);
        r.full  = (held_count == CAPACITY);
        r.empty = (held_count == 0);
        return r;
    endfunction

    function automatic void check_field(string name, logic [FIELD_W-1:0] want,
                                        logic [FIELD_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            bad_fields++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 0;
            bad_fields = 0;
            list_replies.delete();
            replies_outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                list_replies.push_back(run_list_op(mode_t'(s_tuser),
                    s_tdata[KEY_W-1:0],
                    s_tdata[KEY_W+FIELD_W-1:KEY_W],
                    s_tdata[IN_FIELDS_W-1:KEY_W+FIELD_W]));
            if (m_tvalid && m_tready)
            begin
                if (list_replies.size() == 0)
                begin
                    $error("reply transfer with no pending operation: %0h", m_tdata);
                    bad_fields++;
                end
                else
                begin
                    oldest = list_replies.pop_front();
                    check_field("ok", oldest.ok, m_tdata[OK_B]);
                    check_field("found_key", oldest.key, m_tdata[FP_LO-1:FK_LO]);
                    check_field("found_payload", oldest.payload, m_tdata[CNT_LO-1:FP_LO]);
                    check_field("entry_count", oldest.count, m_tdata[FULL_B-1:CNT_LO]);
                    check_field("is_full", oldest.full, m_tdata[FULL_B]);
                    check_field("is_empty", oldest.empty, m_tdata[EMPTY_B]);
                end
            end
            replies_outstanding <= list_replies.size();
        end
    end

endmodule

// ===== bench/bounded_sorted_list_engine_unit_tb.sv =====
// top of the sorted list engine bench: clock, reset, operation stream and verdict
`timescale 1ns / 1ps

module bounded_sorted_list_engine_unit_tb
    import bsle_pkg::*;
();

    localparam int RANDOM_OPS  = 600;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 8;

    // phases of the random stream
    localparam int PH_GROW   = 0;
    localparam int PH_SHRINK = 1;
    localparam int PH_MIXED  = 2;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [MODE_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int mismatch_count;
    int replies_outstanding;
    int cycle_count;

    // keys recently added, reused so that key drops and finds hit
    logic [KEY_W-1:0] key_pool [8];
    bit               sender_bursting;

    bounded_sorted_list_engine_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bsle_reply_checker checker_i (
        .clk                 (clk),
        .rst_n               (rst_n),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .s_tuser             (s_tuser),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .mismatch_count      (mismatch_count),
        .replies_outstanding (replies_outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    // offer one operation and hold it until the engine takes the transfer
    task automatic send_op(input mode_t op, input logic [KEY_W-1:0] k,
                           input logic [FIELD_W-1:0] p, input logic [IDX_W-1:0] idx);
        int gap;
        gap = sender_bursting ? 0 : idle_cycles();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, idx, p, k};
        // s_tready read here is the value seen at this edge
        do @(posedge clk); while (!s_tready);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return key_pool[3'($urandom_range(0, 7))];
        else if (r < 65)
            return 32'h8000_0000;
        else if (r < 70)
            return 32'h7fff_ffff;
        else if (r < 80)
            return KEY_W'($urandom_range(0, 6)) - 32'd3;
        return $urandom;
    endfunction

    function automatic mode_t pick_mode(int phase);
        int r;
        r = $urandom_range(0, 99);
        if (phase == PH_MIXED)
            return mode_t'($urandom_range(0, 7));
        if (r < 60)
            return (phase == PH_GROW) ? mode_t'($urandom_range(0, 2))
                                      : mode_t'($urandom_range(3, 5));
        if (r < 80)
            return mode_t'($urandom_range(6, 7));
        return (phase == PH_GROW) ? mode_t'($urandom_range(3, 5))
                                  : mode_t'($urandom_range(0, 2));
    endfunction

    // result side: random back-pressure, one long hold-off early on so a result
    // waits untaken and the engine stalls its input
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        repeat (4)
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            gap = idle_cycles();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            gap = idle_cycles();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin
        int   sent;
        int   phase;
        int   phase_left;
        int   i;
        mode_t op;
        logic [KEY_W-1:0] k;

        rst_n           <= 1'b0;
        s_tvalid        <= 1'b0;
        s_tuser         <= MODE_ADD_TAIL;
        s_tdata         <= '0;
        sender_bursting = 1'b0;
        for (i = 0; i < 8; i++)
            key_pool[i] = KEY_W'(i);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every refusal on an empty list
        send_op(MODE_DROP_TAIL, 32'd0, 32'd0, 4'd0);
        send_op(MODE_DROP_HEAD, 32'd0, 32'd0, 4'd0);
        send_op(MODE_DROP_KEY, 32'd0, 32'd0, 4'd0);
        send_op(MODE_READ_INDEX, 32'd0, 32'd0, 4'd0);
        send_op(MODE_FIND_KEY, 32'd0, 32'd0, 4'd0);

        // extreme and equal keys through the sorted add, plus both ends
        send_op(MODE_ADD_SORTED, 32'd0, 32'h1111_1111, 4'd0);
        send_op(MODE_ADD_SORTED, 32'd0, 32'h2222_2222, 4'd0);
        send_op(MODE_ADD_SORTED, 32'h7fff_ffff, 32'h3333_3333, 4'd0);
        send_op(MODE_ADD_SORTED, 32'h8000_0000, 32'h4444_4444, 4'd0);
        send_op(MODE_ADD_SORTED, 32'hffff_ffff, 32'h5555_5555, 4'd0);
        send_op(MODE_ADD_TAIL, 32'd5, 32'hffff_ffff, 4'd0);
        send_op(MODE_ADD_HEAD, 32'd3, 32'h0000_0000, 4'd0);

        // fill to capacity, then an add that must be refused
        for (i = 7; i < CAPACITY; i++)
            send_op(mode_t'($urandom_range(0, 2)), pick_key(), $urandom, 4'd0);
        send_op(MODE_ADD_TAIL, 32'd9, 32'hdead_beef, 4'd0);
        send_op(MODE_READ_INDEX, 32'd0, 32'd0, 4'd15);

        // misses on a full list, then hits on the duplicated key, drops at both ends and a read
        send_op(MODE_FIND_KEY, 32'h1234_5678, 32'd0, 4'd0);
        send_op(MODE_DROP_KEY, 32'h1234_5678, 32'd0, 4'd0);
        send_op(MODE_FIND_KEY, 32'd0, 32'd0, 4'd0);
        send_op(MODE_DROP_KEY, 32'd0, 32'd0, 4'd0);
        send_op(MODE_DROP_HEAD, 32'd0, 32'd0, 4'd0);
        send_op(MODE_DROP_TAIL, 32'd0, 32'd0, 4'd0);
        send_op(MODE_READ_INDEX, 32'd0, 32'd0, 4'd14);

        // random: phases that push the list toward full, toward empty or stir it
        sent       = 0;
        phase_left = 0;
        phase      = PH_MIXED;
        while (sent < RANDOM_OPS)
        begin
            if (phase_left == 0)
            begin
                phase           = $urandom_range(0, 2);
                phase_left      = $urandom_range(10, 40);
                sender_bursting = ($urandom_range(0, 3) == 0);
            end
            op = pick_mode(phase);
            k  = pick_key();
            if (op inside {MODE_ADD_TAIL, MODE_ADD_HEAD, MODE_ADD_SORTED} &&
                $urandom_range(0, 1) == 0)
                key_pool[3'($urandom_range(0, 7))] = k;
            send_op(op, k, $urandom, IDX_W'($urandom_range(0, 15)));
            sent++;
            phase_left--;
        end
        s_tvalid <= 1'b0;

        // let every reply come back, then wait out DRAIN_WAIT for anything stray
        do @(posedge clk); while (replies_outstanding != 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0 && replies_outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bsle_pkg.sv
sv/bsle_cell.sv
sv/bounded_sorted_list_engine_unit.sv
bench/bsle_reply_checker.sv
bench/bounded_sorted_list_engine_unit_tb.sv
